// ----- design/brb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_pkg - shared types and codes for the byte ring buffer
// Input and result beat layouts, function codes and line delimiters.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int FILL_W = 11;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_LINE  = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  data_byte;
    logic        first_of_block;
    logic [15:0] count;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        out_byte;
    logic              valid_byte;
    logic              accepted;
    logic              last;
    logic [FILL_W-1:0] fill_level;
  } out_item_t;

endpackage

// ----- design/byte_ring_buffer_with_line_read_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_line_read_core - byte ring buffer with line reads
// Ring store of DEPTH bytes in one synchronous RAM. Takes write blocks one
// byte per beat, judged whole on their first byte, and serves counted reads
// and line reads of up to MAX_READ bytes per command.
// ----------------------------------------------------------------------------
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+-----------------------------------
//  input    | start, busy, in_data      | beat taken when start && !busy
//  result   | out_strobe, out_data      | one cycle per beat, no back-pressure
//  config   | cfg_we, cfg_wdata         | overwrite enable, written on cfg_we
//
//  A write beat never raises busy; its status beat (on the last byte of a
//  block, or on a stray byte) appears on the next cycle. A read command
//  is latched first, then its bytes come out of the RAM read port one
//  byte per cycle, with busy high until the last byte is popped.
//  An empty read gives its single beat on the next cycle, never raising busy.
//  Reset clears pointers, level, block state and the overwrite enable; the
//  RAM contents are not cleared. The receiver cannot stall, so nothing here
//  waits on the result side.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_line_read_core #(
  parameter int DEPTH    = 1024,
  parameter int MAX_READ = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  brb_pkg::in_item_t  in_data,
  output logic               out_strobe,
  output brb_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W  = $clog2(DEPTH + 1);
  localparam int RD_W   = $clog2(MAX_READ + 1);
  localparam int CMP_W  = ((LVL_W > 16) ? LVL_W : 16) + 1;
  localparam int FILL_W = brb_pkg::FILL_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  // Control state
  logic              state_r, state_nxt;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic              blk_ok_r, blk_ok_nxt;
  logic [15:0]       blk_rem_r, blk_rem_nxt;
  logic              ow_en_r;
  logic              line_r, line_nxt;
  logic [RD_W-1:0]   limit_r, limit_nxt;
  logic [RD_W-1:0]   idx_r, idx_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  brb_pkg::out_item_t out_data_r, out_data_nxt;

  // Byte store and its read port
  logic [7:0]        mem [DEPTH];
  logic [7:0]        rdata_r;
  logic              fwd_r;
  logic [7:0]        fwd_byte_r;
  logic              mem_we;
  logic [7:0]        rd_byte;

  // Helpers
  logic [PTR_W-1:0]  rp_inc, wp_inc;
  logic [15:0]       blk_len;
  logic              blk_fits;
  logic [RD_W-1:0]   cmd_limit;
  logic [LVL_W-1:0]  level_dec;
  logic              rd_stop;

  assign rp_inc = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
  assign wp_inc = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);

  // A zero length block counts as a block of one byte.
  assign blk_len  = (in_data.count == 16'd0) ? 16'd1 : in_data.count;
  // Strict compare: a block that would exactly fill the store is refused.
  assign blk_fits = (CMP_W'(level_r) + CMP_W'(blk_len)) < CMP_W'(DEPTH);

  assign cmd_limit = (in_data.count < 16'(MAX_READ)) ? RD_W'(in_data.count)
                                                     : RD_W'(MAX_READ);

  // The RAM output holds the entry at rp_r; take the bypass when that entry
  // was written on the same edge the read was launched.
  assign rd_byte   = fwd_r ? fwd_byte_r : rdata_r;
  assign level_dec = level_r - LVL_W'(1);
  assign rd_stop   = (level_dec == '0) ||
                     (line_r && ((rd_byte == brb_pkg::CHAR_LF) ||
                                 (rd_byte == brb_pkg::CHAR_NUL))) ||
                     ((idx_r + RD_W'(1)) == limit_r);

  always_comb begin
    state_nxt      = state_r;
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    level_nxt      = level_r;
    blk_ok_nxt     = blk_ok_r;
    blk_rem_nxt    = blk_rem_r;
    line_nxt       = line_r;
    limit_nxt      = limit_r;
    idx_nxt        = idx_r;
    mem_we         = 1'b0;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_data.func)
            brb_pkg::FUNC_WRITE: begin
              if (!in_data.first_of_block && (blk_rem_r == 16'd0)) begin
                // Stray byte outside any block: drop it and report a reject.
                out_strobe_nxt          = 1'b1;
                out_data_nxt.kind       = brb_pkg::KIND_STATUS;
                out_data_nxt.last       = 1'b1;
                out_data_nxt.fill_level = FILL_W'(level_r);
              end else begin
                // A new first byte drops any open block silently.
                if (in_data.first_of_block) begin
                  blk_ok_nxt  = ow_en_r || blk_fits;
                  blk_rem_nxt = blk_len - 16'd1;
                end else begin
                  blk_rem_nxt = blk_rem_r - 16'd1;
                end
                if (blk_ok_nxt) begin
                  mem_we = 1'b1;
                  wp_nxt = wp_inc;
                  if (level_r < LVL_W'(DEPTH)) begin
                    level_nxt = level_r + LVL_W'(1);
                  end
                  // Full store: the oldest byte goes, read pointer follows.
                  if (level_nxt == LVL_W'(DEPTH)) begin
                    rp_nxt = wp_inc;
                  end
                end
                if (blk_rem_nxt == 16'd0) begin
                  out_strobe_nxt          = 1'b1;
                  out_data_nxt.kind       = brb_pkg::KIND_STATUS;
                  out_data_nxt.accepted   = blk_ok_nxt;
                  out_data_nxt.last       = 1'b1;
                  out_data_nxt.fill_level = FILL_W'(level_nxt);
                end
              end
            end
            brb_pkg::FUNC_READ, brb_pkg::FUNC_LINE: begin
              if ((cmd_limit == '0) || (level_r == '0)) begin
                // Nothing to hand out: one empty data beat.
                out_strobe_nxt          = 1'b1;
                out_data_nxt.kind       = brb_pkg::KIND_DATA;
                out_data_nxt.last       = 1'b1;
                out_data_nxt.fill_level = FILL_W'(level_r);
              end else begin
                state_nxt = ST_READ;
                line_nxt  = (in_data.func == brb_pkg::FUNC_LINE);
                limit_nxt = cmd_limit;
                idx_nxt   = '0;
              end
            end
            default: begin
              // Unused function code: ignore.
            end
          endcase
        end
      end
      ST_READ: begin
        // Pop one byte per cycle; the RAM already reads the next entry.
        rp_nxt                  = rp_inc;
        level_nxt               = level_dec;
        idx_nxt                 = idx_r + RD_W'(1);
        out_strobe_nxt          = 1'b1;
        out_data_nxt.kind       = brb_pkg::KIND_DATA;
        out_data_nxt.out_byte   = rd_byte;
        out_data_nxt.valid_byte = 1'b1;
        out_data_nxt.last       = rd_stop;
        out_data_nxt.fill_level = FILL_W'(level_dec);
        if (rd_stop) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rp_r         <= '0;
      wp_r         <= '0;
      level_r      <= '0;
      blk_ok_r     <= 1'b0;
      blk_rem_r    <= '0;
      ow_en_r      <= 1'b0;
      line_r       <= 1'b0;
      limit_r      <= '0;
      idx_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rp_r         <= rp_nxt;
      wp_r         <= wp_nxt;
      level_r      <= level_nxt;
      blk_ok_r     <= blk_ok_nxt;
      blk_rem_r    <= blk_rem_nxt;
      line_r       <= line_nxt;
      limit_r      <= limit_nxt;
      idx_r        <= idx_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        ow_en_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // Byte store: write at wp_r, read at the next read pointer.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= in_data.data_byte;
    end
    rdata_r    <= mem[rp_nxt];
    fwd_r      <= mem_we && (wp_r == rp_nxt);
    fwd_byte_r <= in_data.data_byte;
  end

  assign busy       = (state_r == ST_READ);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

`ifndef SYNTHESIS
  a_read_emits_beat : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> out_strobe_r)
    else $error("read cycle gave no result beat");

  a_level_bound : assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_W'(DEPTH))
    else $error("fill level above depth");

  a_ptr_level : assert property (@(posedge clk) disable iff (!rst_n)
    (rp_r == wp_r) == ((level_r == '0) || (level_r == LVL_W'(DEPTH))))
    else $error("pointers disagree with fill level");

  a_last_ends_read : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_data_r.last && (out_data_r.kind == brb_pkg::KIND_DATA))
      |-> (state_r == ST_IDLE))
    else $error("read still running after its last beat");
`endif

endmodule

// ----- tb/sv/byte_ring_buffer_with_line_read_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_with_line_read_core_test - self-checking ring buffer bench
// Drives write blocks, counted reads and line reads into the core, predicts
// every result beat from a cycle-free model of the ring, and checks each beat
// field by field in arrival order. A directed table runs first, then blocks
// sized at the edge of the free room, then random traffic under both
// overwrite settings.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_line_read_core_test;

  localparam int RING_DEPTH  = 1024;
  localparam int READ_CAP    = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_CAP   = 40;

  // One row of the directed table: the beat to send, and optionally the
  // result beat typed in by hand (used instead of the prediction).
  typedef struct {
    brb_pkg::in_item_t  beat;
    bit                 pinned;
    brb_pkg::out_item_t want;
  } dir_row_t;

  localparam brb_pkg::out_item_t NO_PIN = '0;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  brb_pkg::in_item_t  in_data;
  logic               out_strobe;
  brb_pkg::out_item_t out_data;
  logic               cfg_we;
  logic               cfg_wdata;

  // Sideband that travels with each beat, driven alongside in_data, so the
  // monitor always sees the pin that belongs to the beat it takes.
  bit                 pin_row;
  brb_pkg::out_item_t pin_want;

  // Ring shadow: storage, pointers, fill and open-block state
  logic [7:0] ring_mem [RING_DEPTH];
  int         rd_ptr;
  int         wr_ptr;
  int         fill;
  bit         blk_ok;
  int         blk_left;
  bit         ovw_en;
  int         peak_fill;

  brb_pkg::out_item_t expected_beats [$];

  int  mismatches;
  int  beats_checked;
  int  beats_sent;
  int  cycle_count;
  bit  gaps_on;
  int  ovw_phases;

  dir_row_t dir_rows [25] = '{
    // empty store: both read kinds give one empty beat
    '{'{brb_pkg::FUNC_READ,  8'h00, 1'b0, 16'd1},     1'b1,
      '{brb_pkg::KIND_DATA,   8'h00, 1'b0, 1'b0, 1'b1, 11'd0}},
    '{'{brb_pkg::FUNC_LINE,  8'h00, 1'b0, 16'd64},    1'b1,
      '{brb_pkg::KIND_DATA,   8'h00, 1'b0, 1'b0, 1'b1, 11'd0}},
    // stray write byte with no block open
    '{'{brb_pkg::FUNC_WRITE, 8'h55, 1'b0, 16'd0},     1'b1,
      '{brb_pkg::KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b1, 11'd0}},
    // zero block length counts as one byte
    '{'{brb_pkg::FUNC_WRITE, 8'hFF, 1'b1, 16'd0},     1'b1,
      '{brb_pkg::KIND_STATUS, 8'h00, 1'b0, 1'b1, 1'b1, 11'd1}},
    // read limit of zero: empty beat even with data held
    '{'{brb_pkg::FUNC_READ,  8'h00, 1'b0, 16'd0},     1'b1,
      '{brb_pkg::KIND_DATA,   8'h00, 1'b0, 1'b0, 1'b1, 11'd1}},
    // unused function code, all other bits high: no beat
    '{'{2'd3,                8'hFF, 1'b1, 16'hFFFF},  1'b0, NO_PIN},
    // largest count, capped to the read limit
    '{'{brb_pkg::FUNC_READ,  8'h00, 1'b1, 16'hFFFF},  1'b1,
      '{brb_pkg::KIND_DATA,   8'hFF, 1'b1, 1'b0, 1'b1, 11'd0}},
    // a, LF, b, NUL, c then three line reads
    '{'{brb_pkg::FUNC_WRITE, 8'h61, 1'b1, 16'd5},     1'b0, NO_PIN},
    '{'{brb_pkg::FUNC_WRITE, brb_pkg::CHAR_LF, 1'b0, 16'd0},   1'b0, NO_PIN},
    '{'{brb_pkg::FUNC_WRITE, 8'h62, 1'b0, 16'd0},     1'b0, NO_PIN},
    '{'{brb_pkg::FUNC_WRITE, brb_pkg::CHAR_NUL, 1'b0, 16'd0},  1'b0, NO_PIN},
    '{'{brb_pkg::FUNC_WRITE, 8'h63, 1'b0, 16'd0},     1'b0, NO_PIN},
    '{'{brb_pkg::FUNC_LINE,  8'h00, 1'b0, 16'd64},    1'b0, NO_PIN},
    '{'{brb_pkg::FUNC_LINE,  8'h00, 1'b0, 16'd64},    1'b0, NO_PIN},
    '{'{brb_pkg::FUNC_LINE,  8'h00, 1'b0, 16'd64},    1'b0, NO_PIN},
    // oversized block left open, then dropped by a new first byte
    '{'{brb_pkg::FUNC_WRITE, 8'h12, 1'b1, 16'hFFFF},  1'b0, NO_PIN},
    '{'{brb_pkg::FUNC_WRITE, 8'h34, 1'b1, 16'd3},     1'b0, NO_PIN},
    '{'{brb_pkg::FUNC_WRITE, 8'h56, 1'b0, 16'd0},     1'b0, NO_PIN},
    '{'{brb_pkg::FUNC_WRITE, 8'h78, 1'b0, 16'd0},     1'b0, NO_PIN},
    // line read stopped by its limit, then a counted read
    '{'{brb_pkg::FUNC_LINE,  8'h00, 1'b0, 16'd2},     1'b0, NO_PIN},
    '{'{brb_pkg::FUNC_READ,  8'h00, 1'b0, 16'd64},    1'b0, NO_PIN},
    // NUL as data through a counted read, then a one-byte line read
    '{'{brb_pkg::FUNC_WRITE, brb_pkg::CHAR_NUL, 1'b1, 16'd2},  1'b0, NO_PIN},
    '{'{brb_pkg::FUNC_WRITE, 8'h80, 1'b0, 16'hAAAA},  1'b0, NO_PIN},
    '{'{brb_pkg::FUNC_READ,  8'h00, 1'b0, 16'd1},     1'b0, NO_PIN},
    '{'{brb_pkg::FUNC_LINE,  8'h00, 1'b0, 16'd1},     1'b0, NO_PIN}
  };

  byte_ring_buffer_with_line_read_core #(
    .DEPTH    (RING_DEPTH),
    .MAX_READ (READ_CAP)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Mismatch reporting: print one line per failure (up to a cap), count all.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
  endtask

  // Queue one predicted beat, tagged with the fill level after it.
  function automatic void queue_beat(input logic kind, input logic [7:0] b,
                                     input logic vld, input logic acc,
                                     input logic lst);
    brb_pkg::out_item_t r;
    r.kind       = kind;
    r.out_byte   = b;
    r.valid_byte = vld;
    r.accepted   = acc;
    r.last       = lst;
    r.fill_level = brb_pkg::FILL_W'(fill);
    expected_beats.push_back(r);
  endfunction

  // Pop the oldest byte; the fill accounting keeps this to written entries.
  function automatic logic [7:0] pop_ring_byte();
    logic [7:0] b;
    b = ring_mem[rd_ptr];
    rd_ptr = (rd_ptr + 1) % RING_DEPTH;
    fill--;
    return b;
  endfunction

  // Store one byte; once full, drag the read pointer along with the writes.
  function automatic void push_ring_byte(input logic [7:0] b);
    ring_mem[wr_ptr] = b;
    wr_ptr = (wr_ptr + 1) % RING_DEPTH;
    if (fill < RING_DEPTH) begin
      fill++;
    end
    if (fill >= RING_DEPTH) begin
      rd_ptr = wr_ptr;
    end
    if (fill > peak_fill) begin
      peak_fill = fill;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Ring predictor: advance the shadow by one accepted beat and queue the
  // result beats it causes, in order.
  // --------------------------------------------------------------------------
  task automatic predict_ring_beats(input brb_pkg::in_item_t it);
    int         lim;
    int         len;
    int         take_n;
    int         produced;
    int         i;
    bit         stop;
    logic [7:0] b;
    lim      = (it.count < READ_CAP) ? int'(it.count) : READ_CAP;
    produced = 0;
    if (it.func == brb_pkg::FUNC_WRITE) begin
      if (it.first_of_block) begin
        // judge the whole block on its first byte; exact fill is rejected
        len      = (it.count == 16'd0) ? 1 : int'(it.count);
        blk_left = len;
        blk_ok   = ovw_en || (fill + len < RING_DEPTH);
      end else if (blk_left == 0) begin
        queue_beat(brb_pkg::KIND_STATUS, 8'h00, 1'b0, 1'b0, 1'b1);
        return;
      end
      if (blk_ok) begin
        push_ring_byte(it.data_byte);
      end
      blk_left--;
      if (blk_left == 0) begin
        queue_beat(brb_pkg::KIND_STATUS, 8'h00, 1'b0, blk_ok, 1'b1);
      end
      return;
    end
    if (it.func == brb_pkg::FUNC_READ) begin
      take_n = (lim < fill) ? lim : fill;
      for (i = 0; i < take_n; i++) begin
        b = pop_ring_byte();
        queue_beat(brb_pkg::KIND_DATA, b, 1'b1, 1'b0, (i + 1 == take_n));
        produced++;
      end
    end else if (it.func == brb_pkg::FUNC_LINE) begin
      i = 0;
      while (i < lim && fill > 0) begin
        b    = pop_ring_byte();
        stop = (fill == 0) || (b == brb_pkg::CHAR_LF) || (b == brb_pkg::CHAR_NUL) ||
               (i + 1 == lim);
        queue_beat(brb_pkg::KIND_DATA, b, 1'b1, 1'b0, stop);
        produced++;
        i++;
        if (stop) begin
          break;
        end
      end
    end else begin
      // unused function code: no beat, no state change
      return;
    end
    if (produced == 0) begin
      queue_beat(brb_pkg::KIND_DATA, 8'h00, 1'b0, 1'b0, 1'b1);
    end
  endtask

  // Compare one result beat with the oldest expectation, field by field.
  task automatic check_result_beat(input brb_pkg::out_item_t got);
    brb_pkg::out_item_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("result beat %h with nothing expected", got));
      return;
    end
    want = expected_beats.pop_front();
    beats_checked++;
    if (got.kind !== want.kind)
      report_mismatch($sformatf("kind got %b want %b", got.kind, want.kind));
    if (got.out_byte !== want.out_byte)
      report_mismatch($sformatf("out_byte got %h want %h", got.out_byte, want.out_byte));
    if (got.valid_byte !== want.valid_byte)
      report_mismatch($sformatf("valid_byte got %b want %b",
                                got.valid_byte, want.valid_byte));
    if (got.accepted !== want.accepted)
      report_mismatch($sformatf("accepted got %b want %b", got.accepted, want.accepted));
    if (got.last !== want.last)
      report_mismatch($sformatf("last got %b want %b", got.last, want.last));
    if (got.fill_level !== want.fill_level)
      report_mismatch($sformatf("fill_level got %0d want %0d",
                                got.fill_level, want.fill_level));
  endtask

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, so the values seen are
  // the ones that were stable through the cycle that the edge ends.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr    = 0;
      wr_ptr    = 0;
      fill      = 0;
      blk_ok    = 1'b0;
      blk_left  = 0;
      ovw_en    = 1'b0;
      peak_fill = 0;
      expected_beats.delete();
    end else begin
      if (cfg_we) begin
        ovw_en = cfg_wdata;
      end
      if (out_strobe) begin
        check_result_beat(out_data);
      end
      if (start && !busy) begin
        predict_ring_beats(in_data);
        // a hand-typed row replaces its single predicted beat
        if (pin_row) begin
          void'(expected_beats.pop_back());
          expected_beats.push_back(pin_want);
        end
      end
    end
  end

  // Watchdog: end the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still expected",
               cycle_count, expected_beats.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender: hold start high until the beat is taken; when gaps are on, drop
  // start for a random burst before some beats.
  // --------------------------------------------------------------------------
  task automatic send_beat(input brb_pkg::in_item_t it, input bit pin,
                           input brb_pkg::out_item_t want);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_data  <= it;
    pin_row  <= pin;
    pin_want <= want;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  // Stop sending and wait until every expected beat is back, then let the
  // last write beats settle before anything else happens.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Change the overwrite enable, only with the core idle.
  task automatic set_overwrite(input bit en);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    ovw_phases++;
  endtask

  // Bias data toward line delimiters so line reads stop early often.
  function automatic logic [7:0] pick_data_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return brb_pkg::CHAR_LF;
    if (r == 1) return brb_pkg::CHAR_NUL;
    return 8'($urandom);
  endfunction

  // Read limits: mostly from 1 to 70, just past the cap, sometimes zero or a full 16-bit count.
  function automatic logic [15:0] pick_read_count();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd0;
    if (r < 4) return 16'($urandom);
    return 16'($urandom_range(1, 70));
  endfunction

  // Send one write block of len bytes, the first carrying count.
  task automatic send_block(input int len, input logic [15:0] count);
    brb_pkg::in_item_t it;
    int                k;
    for (k = 0; k < len; k++) begin
      it.func           = brb_pkg::FUNC_WRITE;
      it.data_byte      = pick_data_byte();
      it.first_of_block = (k == 0);
      it.count          = (k == 0) ? count : 16'($urandom);
      send_beat(it, 1'b0, NO_PIN);
    end
  endtask

  // --------------------------------------------------------------------------
  // Random traffic: mostly complete blocks and reads, some noise (stray bytes,
  // abandoned blocks, zero-length blocks, unused function code).
  // --------------------------------------------------------------------------
  task automatic send_random_traffic(input int n_items);
    brb_pkg::in_item_t it;
    int                done;
    int                r;
    int                len;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                          : $urandom_range(1, 8);
        send_block(len, 16'(len));
        done += len;
      end else if (r < 90) begin
        it.func           = (r < 65) ? brb_pkg::FUNC_READ : brb_pkg::FUNC_LINE;
        it.data_byte      = 8'($urandom);
        it.first_of_block = 1'($urandom);
        it.count          = pick_read_count();
        send_beat(it, 1'b0, NO_PIN);
        done++;
      end else if (r < 93) begin
        // non-first byte: stray unless a block was left open
        it.func           = brb_pkg::FUNC_WRITE;
        it.data_byte      = pick_data_byte();
        it.first_of_block = 1'b0;
        it.count          = 16'($urandom);
        send_beat(it, 1'b0, NO_PIN);
        done++;
      end else if (r < 96) begin
        // open a long block and abandon it after a few bytes
        len = $urandom_range(1, 5);
        send_block(len, 16'($urandom_range(6, 65535)));
        done += len;
      end else if (r < 98) begin
        send_block(1, 16'd0);
        done++;
      end else begin
        it.func           = 2'd3;
        it.data_byte      = 8'($urandom);
        it.first_of_block = 1'($urandom);
        it.count          = 16'($urandom);
        send_beat(it, 1'b0, NO_PIN);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    brb_pkg::in_item_t it;
    int                k;
    int                room;
    clk           = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    pin_row       = 1'b0;
    pin_want      = '0;
    mismatches    = 0;
    beats_checked = 0;
    beats_sent    = 0;
    cycle_count   = 0;
    gaps_on       = 1'b1;
    ovw_phases    = 0;
    foreach (ring_mem[k]) ring_mem[k] = 8'h00;

    // hold reset, once
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, overwrite off (written explicitly)
    set_overwrite(1'b0);
    foreach (dir_rows[k]) begin
      send_beat(dir_rows[k].beat, dir_rows[k].pinned, dir_rows[k].want);
    end

    // blocks at the edge of the free room, no gaps: one that would exactly
    // fill the store (refused), one a byte short (taken), both left open,
    // then a short block that drops the open one, and a read to drain
    drain_results();
    gaps_on = 1'b0;
    room    = RING_DEPTH - fill;
    send_block(3, 16'(room));
    send_block(3, 16'(room - 1));
    send_block(4, 16'd4);
    it.func           = brb_pkg::FUNC_READ;
    it.data_byte      = 8'h00;
    it.first_of_block = 1'b0;
    it.count          = 16'd64;
    send_beat(it, 1'b0, NO_PIN);

    // overwrite on: an oversized block is taken, then ordinary traffic
    set_overwrite(1'b1);
    send_block(3, 16'hFFFF);
    send_block(12, 16'd12);
    for (k = 0; k < 6; k++) begin
      it.func           = (k % 2 == 0) ? brb_pkg::FUNC_READ : brb_pkg::FUNC_LINE;
      it.data_byte      = 8'h00;
      it.first_of_block = 1'b0;
      it.count          = 16'd64;
      send_beat(it, 1'b0, NO_PIN);
    end

    // random traffic with gaps, under both settings
    gaps_on = 1'b1;
    send_random_traffic(45);
    set_overwrite(1'b0);
    send_random_traffic(35);

    // last stretch: back to back
    gaps_on = 1'b0;
    send_random_traffic(20);

    // wait out the remaining results, then keep watching for strays
    start <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0 && cycle_count < CYCLE_LIMIT - 100) @(posedge clk);
    repeat (80) @(posedge clk);
    if (expected_beats.size() != 0) begin
      report_mismatch($sformatf("%0d expected beats never arrived", expected_beats.size()));
    end

    $display("Run covered %0d input beats and %0d result beats, peak fill %0d of %0d,",
             beats_sent, beats_checked, peak_fill, RING_DEPTH);
    $display("across %0d overwrite settings; %0d mismatches", ovw_phases, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/brb_pkg.sv
design/byte_ring_buffer_with_line_read_core.sv
tb/sv/byte_ring_buffer_with_line_read_core_test.sv
